[hw/rtl/multi_level_page_table_first_touch_macros.svh]
// ----------------------------------------------------------------------------
// Page table walker assertion macros
// Shorthand for clocked, reset-qualified implication checks.
// ----------------------------------------------------------------------------
`ifndef MULTI_LEVEL_PAGE_TABLE_FIRST_TOUCH_MACROS_SVH
`define MULTI_LEVEL_PAGE_TABLE_FIRST_TOUCH_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define MLPT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MLPT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/mlpt_pkg.sv]
// ----------------------------------------------------------------------------
// mlpt_pkg
// Shared constants and codes of the multi-level page table walker.
// ----------------------------------------------------------------------------
package mlpt_pkg;

   localparam int DEF_SLOT_POOL    = 65536;
   localparam int DEF_ADDRESS_BITS = 32;

   localparam int MAX_LEVELS       = 4;
   localparam int REG_LEVELS       = 4;
   localparam int MAX_LEVEL_BITS   = 16;

   localparam int ADDR_PORT_BITS   = 32;
   localparam int FRAME_BITS       = 16;
   localparam int PHYS_BITS        = 47;
   localparam int STATUS_BITS      = 2;

   localparam int COUNT_FIELD_BITS = 3;
   localparam int LEVEL_FIELD_BITS = 5;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 5;

   typedef logic [STATUS_BITS-1:0]    status_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   // result status codes
   localparam status_type ST_HIT  = 2'd0;
   localparam status_type ST_NEW  = 2'd1;
   localparam status_type ST_FULL = 2'd2;
   localparam status_type ST_BAD  = 2'd3;

   // register indexes
   localparam csr_index_type CSR_LEVEL_COUNT = 3'd0;
   localparam csr_index_type CSR_BITS_ZERO   = 3'd1;
   localparam csr_index_type CSR_BITS_ONE    = 3'd2;
   localparam csr_index_type CSR_BITS_TWO    = 3'd3;
   localparam csr_index_type CSR_BITS_THREE  = 3'd4;

endpackage

[hw/rtl/multi_level_page_table_first_touch.sv]
// ----------------------------------------------------------------------------
// multi_level_page_table_first_touch
// Radix page table walker with first-touch node and frame allocation.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one logical address per beat (valid/stall, block drives stall).
//   rsp_*  : one result per beat: frame, status, physical address.
//   csr_*  : register writes (index, data), always ready; write only when idle.
// States walked from a request beat to EMIT, with n levels in use:
//   hit                  : CHECK, then READ and WAIT for each of the n levels
//   miss at level m      : hit path to level m, NEED, ALLOC per lower level, LEAF
//   bad config/pool full : CHECK (pool full from the walk: that READ, or NEED)
// One address is walked at a time; the next request beat is taken in IDLE,
// which is entered as the result moves to the output register. The walk is
// bound by the single slot memory: one dependent read per level and one
// write per new node, plus one for the leaf frame.
// Reset: control state clears, then the slot memory is swept to zero, one
// slot a cycle, with req_stall high; csr writes are taken.
// A stalled result holds in the output register; the walker keeps the next
// result in its finish state until the output register frees up.
// ----------------------------------------------------------------------------
module multi_level_page_table_first_touch
   import mlpt_pkg::*;
#(
   parameter int SLOT_POOL    = DEF_SLOT_POOL,
   parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ADDR_PORT_BITS-1:0]   req_logical_address,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [FRAME_BITS-1:0]       rsp_frame_number,
   output logic [STATUS_BITS-1:0]      rsp_status,
   output logic [PHYS_BITS-1:0]        rsp_physical_address,
   // register write channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]    csr_data
);

   // ------------------------------------------------------------------------
   // Widths
   // ------------------------------------------------------------------------
   localparam int MEM_AW  = $clog2(SLOT_POOL);
   // stored value: node base (< SLOT_POOL) or frame (16 bits)
   localparam int VAL_W   = (MEM_AW > FRAME_BITS) ? MEM_AW : FRAME_BITS;
   // base + index sum, before the pool bound check
   localparam int SLOT_W  = VAL_W + 1;
   // slots in use; also holds a full 2^16 root
   localparam int USED_RAW = $clog2(SLOT_POOL + 1);
   localparam int USED_W  = (USED_RAW > FRAME_BITS + 1) ? USED_RAW : FRAME_BITS + 1;
   // up to three new nodes on top of the used count
   localparam int NEED_W  = USED_W + 2;
   localparam int LVL_W   = $clog2(REG_LEVELS);
   localparam int SHIFT_W = $clog2(ADDR_PORT_BITS + 1);
   localparam int SUM_W   = LEVEL_FIELD_BITS + LVL_W;
   localparam int NFRM_W  = FRAME_BITS + 1;

   localparam logic [ADDR_PORT_BITS-1:0] ADDR_MASK =
      ADDR_PORT_BITS'((64'd1 << ADDRESS_BITS) - 64'd1);
   localparam logic [SLOT_W-1:0]  POOL_S    = SLOT_W'(SLOT_POOL);
   localparam logic [USED_W-1:0]  POOL_U    = USED_W'(SLOT_POOL);
   localparam logic [NEED_W-1:0]  POOL_N    = NEED_W'(SLOT_POOL);
   localparam logic [MEM_AW-1:0]  LAST_SLOT = MEM_AW'(SLOT_POOL - 1);
   localparam logic [SUM_W-1:0]   SUM_LIMIT = SUM_W'(ADDRESS_BITS - 1);

   // Slot entry. post_clear is set when the slot had already been handed out
   // (and so zeroed) at write time. An entry written past the allocation
   // mark dies once a later node allocation covers that slot, which is what
   // zeroing a new node would do, without sweeping it.
   typedef struct packed {
      logic             valid;
      logic             post_clear;
      logic [VAL_W-1:0] value;
   } slot_entry_type;

   typedef enum logic [3:0] {
      S_CLEAR,    // post-reset memory sweep
      S_IDLE,     // waiting for a request beat
      S_CHECK,    // config check, root sizing
      S_READ,     // index extract, issue slot read
      S_WAIT,     // slot data back: descend, hit or miss
      S_NEED,     // room check for new nodes and frame
      S_ALLOC,    // carve one node, link its parent
      S_LEAF,     // write the leaf frame, commit
      S_EMIT      // hand result to the output register
   } state_type;

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   state_type                    state_ff,        state_in;
   logic [MEM_AW-1:0]            clr_ff,          clr_in;

   logic [COUNT_FIELD_BITS-1:0]  level_count_ff,  level_count_in;
   logic [LEVEL_FIELD_BITS-1:0]  level_bits_ff [REG_LEVELS];
   logic [LEVEL_FIELD_BITS-1:0]  level_bits_in [REG_LEVELS];

   logic [USED_W-1:0]            next_free_ff,    next_free_in;
   logic [NFRM_W-1:0]            next_frame_ff,   next_frame_in;

   logic [ADDR_PORT_BITS-1:0]    addr_ff,         addr_in;
   logic [LVL_W-1:0]             lvl_ff,          lvl_in;
   logic [SHIFT_W-1:0]           shift_ff,        shift_in;
   logic [SHIFT_W-1:0]           offbits_ff,      offbits_in;
   logic [VAL_W-1:0]             base_ff,         base_in;
   logic [MEM_AW-1:0]            slot_ff,         slot_in;
   logic [USED_W-1:0]            used_ff,         used_in;
   logic [FRAME_BITS-1:0]        res_frame_ff,    res_frame_in;
   status_type                   res_status_ff,   res_status_in;

   logic                         rsp_valid_ff,    rsp_valid_in;
   logic [FRAME_BITS-1:0]        rsp_frame_ff,    rsp_frame_in;
   status_type                   rsp_status_ff,   rsp_status_in;
   logic [PHYS_BITS-1:0]         rsp_phys_ff,     rsp_phys_in;

   // slot memory
   slot_entry_type               slot_mem [SLOT_POOL];
   slot_entry_type               mem_rd_data_ff;
   logic                         mem_rd_en;
   logic [MEM_AW-1:0]            mem_rd_addr;
   logic                         mem_wr_en;
   logic [MEM_AW-1:0]            mem_wr_addr;
   slot_entry_type               mem_wr_data;

   // ------------------------------------------------------------------------
   // Shared index datapath: level select, index extract, slot add
   // ------------------------------------------------------------------------
   logic [LVL_W-1:0]             lvl_sel;
   logic [LEVEL_FIELD_BITS-1:0]  bw_sel;
   logic [SHIFT_W-1:0]           shift_next;
   logic [ADDR_PORT_BITS-1:0]    addr_shifted;
   logic [FRAME_BITS-1:0]        idx_mask;
   logic [FRAME_BITS-1:0]        idx;
   logic [VAL_W-1:0]             base_op;
   logic [SLOT_W-1:0]            slot_sum;
   logic [USED_W-1:0]            node_size;
   logic [USED_W-1:0]            used_grown;

   // ALLOC works on the level below the one just linked
   assign lvl_sel      = (state_ff == S_ALLOC) ? lvl_ff + LVL_W'(1) : lvl_ff;
   assign bw_sel       = level_bits_ff[lvl_sel];
   assign shift_next   = shift_ff - SHIFT_W'(bw_sel);
   assign addr_shifted = addr_ff >> shift_next;
   assign idx_mask     = FRAME_BITS'(((FRAME_BITS + 1)'(1) << bw_sel) - (FRAME_BITS + 1)'(1));
   assign idx          = addr_shifted[FRAME_BITS-1:0] & idx_mask;
   // new node base is the current allocation mark
   assign base_op      = (state_ff == S_ALLOC) ? VAL_W'(used_ff) : base_ff;
   assign slot_sum     = SLOT_W'(base_op) + SLOT_W'(idx);
   assign node_size    = USED_W'(1) << bw_sel;
   assign used_grown   = used_ff + node_size;

   // ------------------------------------------------------------------------
   // Config check (only meaningful while the registers are stable)
   // ------------------------------------------------------------------------
   logic                         cfg_bad;
   logic [SUM_W-1:0]             bits_sum;
   logic [USED_W-1:0]            used_start;
   logic [COUNT_FIELD_BITS-1:0]  last_level;
   logic                         at_last;

   always_comb begin
      cfg_bad  = (level_count_ff == '0)
              || (level_count_ff > COUNT_FIELD_BITS'(REG_LEVELS))
              || (level_count_ff > COUNT_FIELD_BITS'(MAX_LEVELS));
      bits_sum = '0;
      for (int d = 0; d < REG_LEVELS; d++) begin
         if (COUNT_FIELD_BITS'(d) < level_count_ff) begin
            if (level_bits_ff[d] == '0
                  || level_bits_ff[d] > LEVEL_FIELD_BITS'(MAX_LEVEL_BITS)) begin
               cfg_bad = 1'b1;
            end
            bits_sum = bits_sum + SUM_W'(level_bits_ff[d]);
         end
      end
      if (bits_sum > SUM_LIMIT) begin
         cfg_bad = 1'b1;
      end
   end

   // root is taken on the first mapping
   assign used_start = (next_free_ff == '0) ? (USED_W'(1) << level_bits_ff[0]) : next_free_ff;
   assign last_level = level_count_ff - COUNT_FIELD_BITS'(1);
   assign at_last    = (COUNT_FIELD_BITS'(lvl_sel) == last_level);

   // slots still needed below the miss level
   logic [NEED_W-1:0] need;
   always_comb begin
      need = '0;
      for (int d = 0; d < REG_LEVELS; d++) begin
         if (LVL_W'(d) > lvl_ff && COUNT_FIELD_BITS'(d) < level_count_ff) begin
            need = need + (NEED_W'(1) << level_bits_ff[d]);
         end
      end
   end

   // read hit rule: written after its zeroing, or never zeroed since
   logic entry_live;
   assign entry_live = mem_rd_data_ff.valid
                    && (mem_rd_data_ff.post_clear || USED_W'(slot_ff) >= used_ff);

   // physical address assembly for the result
   logic [ADDR_PORT_BITS-1:0] off_mask;
   logic [PHYS_BITS-1:0]      phys;
   assign off_mask = (ADDR_PORT_BITS'(1) << offbits_ff) - ADDR_PORT_BITS'(1);
   assign phys     = (res_status_ff == ST_HIT || res_status_ff == ST_NEW)
                   ? ((PHYS_BITS'(res_frame_ff) << offbits_ff)
                      | PHYS_BITS'(addr_ff & off_mask))
                   : '0;

   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      level_count_in = level_count_ff;
      level_bits_in  = level_bits_ff;
      next_free_in   = next_free_ff;
      next_frame_in  = next_frame_ff;
      addr_in        = addr_ff;
      lvl_in         = lvl_ff;
      shift_in       = shift_ff;
      offbits_in     = offbits_ff;
      base_in        = base_ff;
      slot_in        = slot_ff;
      used_in        = used_ff;
      res_frame_in   = res_frame_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_frame_in   = rsp_frame_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_phys_in    = rsp_phys_ff;

      mem_rd_en      = 1'b0;
      mem_rd_addr    = slot_sum[MEM_AW-1:0];
      mem_wr_en      = 1'b0;
      mem_wr_addr    = slot_ff;
      mem_wr_data    = '0;

      // register writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LEVEL_COUNT: level_count_in   = csr_data[COUNT_FIELD_BITS-1:0];
            CSR_BITS_ZERO:   level_bits_in[0] = csr_data;
            CSR_BITS_ONE:    level_bits_in[1] = csr_data;
            CSR_BITS_TWO:    level_bits_in[2] = csr_data;
            CSR_BITS_THREE:  level_bits_in[3] = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            clr_in      = clr_ff + MEM_AW'(1);
            if (clr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               addr_in  = req_logical_address & ADDR_MASK;
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            res_frame_in = '0;
            lvl_in       = '0;
            base_in      = '0;
            shift_in     = SHIFT_W'(ADDRESS_BITS);
            offbits_in   = SHIFT_W'(SUM_W'(ADDRESS_BITS) - bits_sum);
            used_in      = used_start;
            if (cfg_bad) begin
               res_status_in = ST_BAD;
               state_in      = S_EMIT;
            end else if (used_start > POOL_U) begin
               res_status_in = ST_FULL;
               state_in      = S_EMIT;
            end else begin
               state_in = S_READ;
            end
         end

         S_READ: begin
            if (slot_sum >= POOL_S) begin
               res_status_in = ST_FULL;
               state_in      = S_EMIT;
            end else begin
               mem_rd_en = 1'b1;
               slot_in   = slot_sum[MEM_AW-1:0];
               shift_in  = shift_next;
               state_in  = S_WAIT;
            end
         end

         S_WAIT: begin
            if (!entry_live) begin
               state_in = S_NEED;
            end else if (at_last) begin
               res_frame_in  = mem_rd_data_ff.value[FRAME_BITS-1:0];
               res_status_in = ST_HIT;
               state_in      = S_EMIT;
            end else begin
               base_in  = mem_rd_data_ff.value;
               lvl_in   = lvl_ff + LVL_W'(1);
               state_in = S_READ;
            end
         end

         S_NEED: begin
            if (need + NEED_W'(used_ff) > POOL_N || next_frame_ff[FRAME_BITS]) begin
               res_status_in = ST_FULL;
               state_in      = S_EMIT;
            end else if (at_last) begin
               state_in = S_LEAF;
            end else begin
               state_in = S_ALLOC;
            end
         end

         S_ALLOC: begin
            // link parent slot to the new node at the allocation mark
            mem_wr_en              = 1'b1;
            mem_wr_data.valid      = 1'b1;
            mem_wr_data.post_clear = USED_W'(slot_ff) < used_grown;
            mem_wr_data.value      = VAL_W'(used_ff);
            used_in                = used_grown;
            shift_in               = shift_next;
            slot_in                = slot_sum[MEM_AW-1:0];
            lvl_in                 = lvl_sel;
            if (at_last) begin
               state_in = S_LEAF;
            end
         end

         S_LEAF: begin
            mem_wr_en              = 1'b1;
            mem_wr_data.valid      = 1'b1;
            mem_wr_data.post_clear = USED_W'(slot_ff) < used_ff;
            mem_wr_data.value      = VAL_W'(next_frame_ff[FRAME_BITS-1:0]);
            next_frame_in          = next_frame_ff + NFRM_W'(1);
            next_free_in           = used_ff;
            res_frame_in           = next_frame_ff[FRAME_BITS-1:0];
            res_status_in          = ST_NEW;
            state_in               = S_EMIT;
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_frame_in  = res_frame_ff;
               rsp_status_in = res_status_ff;
               rsp_phys_in   = phys;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // State and registered outputs
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      lvl_ff        <= lvl_in;
      shift_ff      <= shift_in;
      offbits_ff    <= offbits_in;
      base_ff       <= base_in;
      slot_ff       <= slot_in;
      used_ff       <= used_in;
      res_frame_ff  <= res_frame_in;
      res_status_ff <= res_status_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_status_ff <= rsp_status_in;
      rsp_phys_ff   <= rsp_phys_in;
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_ff         <= '0;
         level_count_ff <= COUNT_FIELD_BITS'(2);
         for (int d = 0; d < REG_LEVELS; d++) begin
            level_bits_ff[d] <= LEVEL_FIELD_BITS'(8);
         end
         next_free_ff   <= '0;
         next_frame_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         level_count_ff <= level_count_in;
         level_bits_ff  <= level_bits_in;
         next_free_ff   <= next_free_in;
         next_frame_ff  <= next_frame_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------------
   // Slot memory: one write port, one registered read port. Walk reads and
   // writes of one address never overlap, so no bypass is needed.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         slot_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         mem_rd_data_ff <= slot_mem[mem_rd_addr];
      end
   end

   // ------------------------------------------------------------------------
   // Ports
   // ------------------------------------------------------------------------
   assign req_stall            = (state_ff != S_IDLE);
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_frame_number     = rsp_frame_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_physical_address = rsp_phys_ff;

endmodule

[hw/rtl/mlpt_checker.sv]
// ----------------------------------------------------------------------------
// mlpt_checker
// Port-level checks of the page table walker, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_level_page_table_first_touch_macros.svh"

module mlpt_checker
   import mlpt_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [FRAME_BITS-1:0]       rsp_frame_number,
   input logic [STATUS_BITS-1:0]      rsp_status,
   input logic [PHYS_BITS-1:0]        rsp_physical_address
);

   // stalled result beat holds
   `MLPT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_frame_number) && $stable(rsp_status) && $stable(rsp_physical_address), "stalled result changed")

   // error results carry no translation
   `MLPT_ASSERT_NOW(a_err_zero, rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_BAD), rsp_frame_number == '0 && rsp_physical_address == '0, "error result not zero")

   // memory sweep follows reset
   `MLPT_ASSERT_NOW(a_sweep_after_reset, $past(reset), req_stall, "request taken during sweep")

   // one walk at a time
   `MLPT_ASSERT_NEXT(a_one_walk, req_valid && !req_stall, req_stall, "request taken mid-walk")

endmodule

bind multi_level_page_table_first_touch mlpt_checker u_mlpt_checker (.*);
